// File: rtl/line_edit_buffer_with_cursor_top_macros.svh
// Assertion macros for the line edit buffer checker.
// Used by lebc_checker.sv only; needs nothing else.
`ifndef LINE_EDIT_BUFFER_WITH_CURSOR_TOP_MACROS_SVH
`define LINE_EDIT_BUFFER_WITH_CURSOR_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define LEBC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define LEBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/lebc_pkg.sv
// Shared types and constants for the line edit buffer.
// No dependencies; imported by every module of the block.
package lebc_pkg;

   localparam int FUNC_W      = 3;
   localparam int STORE_W     = 7;
   localparam int CHUNK_BYTES = 8;
   localparam int CHUNK_W     = CHUNK_BYTES * 8;
   localparam int COUNT_W     = 4;

   // command codes
   localparam logic [FUNC_W-1:0] FUNC_HOME  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_END   = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_LEFT  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_RIGHT = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_TYPE  = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_ERASE = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_PRINT = 3'd6;

   localparam logic [7:0] PRINT_LOW        = 8'd32;
   localparam logic [7:0] PRINT_HIGH       = 8'd126;
   localparam logic [7:0] MAX_LENGTH_RESET = 8'd100;

   localparam logic [COUNT_W-1:0] COUNT_FULL = 4'd8;

   localparam logic STATUS_DONE    = 1'b0;
   localparam logic STATUS_REFUSED = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_DRAIN,
      ST_INSERT,
      ST_PRINT_FETCH,
      ST_PRINT
   } state_type;

   typedef struct packed {
      logic clear;
      logic push;
   } pack_ctl_type;

endpackage

// File: rtl/lebc_packer.sv
// Byte packer: gathers printed bytes into an 8-byte chunk.
// Depends on lebc_pkg.
module lebc_packer
   import lebc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  pack_ctl_type        ctl,
   input  logic [7:0]          push_byte,
   output logic [CHUNK_W-1:0]  chunk,
   output logic [COUNT_W-1:0]  count
);

   logic [CHUNK_W-1:0] chunk_ff, chunk_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   always_comb begin
      chunk_in = chunk_ff;
      count_in = count_ff;
      if (ctl.clear) begin
         chunk_in = '0;
         count_in = '0;
      end else if (ctl.push) begin
         if (count_ff == COUNT_FULL) begin
            // full chunk went out this cycle; restart with the new byte
            chunk_in = {{(CHUNK_W-8){1'b0}}, push_byte};
            count_in = COUNT_W'(1);
         end else begin
            for (int l = 0; l < CHUNK_BYTES; l++) begin
               if (count_ff[2:0] == 3'(l)) chunk_in[l*8 +: 8] = push_byte;
            end
            count_in = count_ff + COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      chunk_ff <= chunk_in;
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign chunk = chunk_ff;
   assign count = count_ff;

endmodule

// File: rtl/line_edit_buffer_with_cursor_top.sv
// Top level of the one-line edit buffer with cursor.
// Depends on lebc_pkg and lebc_packer.
//
// Usage:
//  - Requests: drive req_func/req_key_byte/req_separator_byte with start; a
//    request is taken on a rising edge with start high and busy low.
//  - Results: one cycle on the rsp_ ports, marked by rsp_valid. The receiver
//    cannot stall, so every result is taken in the cycle it shows.
//  - Config: csr_wr_en with csr_wr_data writes max_length (no wait); write it
//    only while no request is in flight.
// Sequencing per request (the result cycle is counted from the accept edge):
//  - home, end, left, right, unknown code, refused type/erase and erase at the
//    end of the line: the next cycle; busy stays low, one request per cycle.
//  - type: SHIFT from the end down to the cursor, DRAIN, then INSERT; at the
//    end of the line INSERT only. Erase inside the line: SHIFT up to the end, DRAIN.
//  - print (text plus optional separator): PRINT_FETCH, then PRINT, chunks
//    of eight bytes going out as they fill.
//  - The slowest request is a print of a full line with a marker; the store
//    has one write and one read port: one entry read and one written per cycle.
// Reset clears length and cursor and loads max_length with 100. The store
// itself is not cleared: only entries below the length are ever used.
module line_edit_buffer_with_cursor_top
   import lebc_pkg::*;
#(
   parameter int BUFFER_DEPTH = 128
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 start,
   output logic                 busy,
   input  logic [FUNC_W-1:0]    req_func,
   input  logic [7:0]           req_key_byte,
   input  logic [7:0]           req_separator_byte,
   // result channel
   output logic                 rsp_valid,
   output logic                 rsp_status,
   output logic [CHUNK_W-1:0]   rsp_text_chunk,
   output logic [COUNT_W-1:0]   rsp_byte_count,
   output logic                 rsp_last,
   // config
   input  logic                 csr_wr_en,
   input  logic [7:0]           csr_wr_data
);

   localparam int LW = $clog2(BUFFER_DEPTH + 1);   // length / cursor width
   localparam int AW = $clog2(BUFFER_DEPTH);       // store address width
   localparam int CW = (LW > 8) ? LW : 8;          // compare width vs max_length
   localparam logic [LW-1:0] ONE_L   = LW'(1);
   localparam logic [LW-1:0] DEPTH_L = LW'(BUFFER_DEPTH);

   state_type state_ff, state_in;

   logic [LW-1:0]       len_ff, len_in;
   logic [LW-1:0]       cur_ff, cur_in;
   logic [7:0]          maxlen_ff, maxlen_in;
   logic [LW-1:0]       ptr_ff, ptr_in;      // shift read pointer
   logic [LW-1:0]       wptr_ff, wptr_in;    // shift write-back pointer
   logic                pend_ff, pend_in;    // read data waiting to be written
   logic                is_type_ff, is_type_in;
   logic [STORE_W-1:0]  key_ff, key_in;
   logic [7:0]          sep_ff, sep_in;
   logic                sep_done_ff, sep_done_in;
   logic [LW-1:0]       idx_ff, idx_in;      // print walk index

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_status_ff, rsp_status_in;
   logic [CHUNK_W-1:0]  rsp_chunk_ff, rsp_chunk_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic                rsp_last_ff, rsp_last_in;

   // character store, one write and one registered read port
   logic [STORE_W-1:0]  store_mem [BUFFER_DEPTH];
   logic [STORE_W-1:0]  rd_data_ff;
   logic                mem_we, mem_re;
   logic [AW-1:0]       mem_waddr, mem_raddr;
   logic [STORE_W-1:0]  mem_wdata;

   pack_ctl_type        pack_ctl;
   logic [7:0]          pack_byte;
   logic [CHUNK_W-1:0]  pack_chunk;
   logic [COUNT_W-1:0]  pack_count;

   logic accept;
   logic key_ok, full, type_ok;
   logic shift_last;
   logic sep_now;
   logic [LW-1:0] idx_nx;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   assign key_ok  = (req_key_byte >= PRINT_LOW) && (req_key_byte <= PRINT_HIGH);
   assign full    = (CW'(len_ff) >= CW'(maxlen_ff)) || (len_ff >= DEPTH_L);
   assign type_ok = key_ok && !full;

   // type walks down to the cursor, erase walks up to the end
   assign shift_last = is_type_ff ? (ptr_ff == cur_ff) : (ptr_ff == len_ff - ONE_L);

   assign sep_now = (idx_ff == cur_ff) && (sep_ff != 8'd0) && !sep_done_ff;
   assign idx_nx  = idx_ff + ONE_L;

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_func)
                  FUNC_TYPE: begin
                     if (type_ok) state_in = (cur_ff == len_ff) ? ST_INSERT : ST_SHIFT;
                  end
                  FUNC_ERASE: begin
                     if (cur_ff != '0 && cur_ff != len_ff) state_in = ST_SHIFT;
                  end
                  FUNC_PRINT: state_in = ST_PRINT_FETCH;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_SHIFT:       if (shift_last) state_in = ST_DRAIN;
         ST_DRAIN:       state_in = is_type_ff ? ST_INSERT : ST_IDLE;
         ST_INSERT:      state_in = ST_IDLE;
         ST_PRINT_FETCH: state_in = ST_PRINT;
         ST_PRINT:       if (!sep_now && idx_ff == len_ff) state_in = ST_IDLE;
         default:        state_in = ST_IDLE;
      endcase
   end

   // ---------------- datapath and outputs ----------------
   always_comb begin
      len_in      = len_ff;
      cur_in      = cur_ff;
      maxlen_in   = csr_wr_en ? csr_wr_data : maxlen_ff;
      ptr_in      = ptr_ff;
      wptr_in     = wptr_ff;
      pend_in     = pend_ff;
      is_type_in  = is_type_ff;
      key_in      = key_ff;
      sep_in      = sep_ff;
      sep_done_in = sep_done_ff;
      idx_in      = idx_ff;

      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_chunk_in  = rsp_chunk_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;

      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_waddr = '0;
      mem_raddr = '0;
      mem_wdata = rd_data_ff;

      pack_ctl  = '0;
      pack_byte = {1'b0, rd_data_ff};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               key_in     = req_key_byte[STORE_W-1:0];
               sep_in     = req_separator_byte;
               is_type_in = (req_func == FUNC_TYPE);
               pend_in    = 1'b0;
               // plain single-result commands answer right away
               rsp_status_in = STATUS_DONE;
               rsp_chunk_in  = '0;
               rsp_count_in  = '0;
               rsp_last_in   = 1'b1;
               case (req_func)
                  FUNC_HOME: begin
                     cur_in       = '0;
                     rsp_valid_in = 1'b1;
                  end
                  FUNC_END: begin
                     cur_in       = len_ff;
                     rsp_valid_in = 1'b1;
                  end
                  FUNC_LEFT: begin
                     if (cur_ff != '0) cur_in = cur_ff - ONE_L;
                     rsp_valid_in = 1'b1;
                  end
                  FUNC_RIGHT: begin
                     if (cur_ff != len_ff) cur_in = cur_ff + ONE_L;
                     rsp_valid_in = 1'b1;
                  end
                  FUNC_TYPE: begin
                     if (!type_ok) begin
                        rsp_status_in = STATUS_REFUSED;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        ptr_in = len_ff - ONE_L;
                     end
                  end
                  FUNC_ERASE: begin
                     if (cur_ff == '0) begin
                        rsp_status_in = STATUS_REFUSED;
                        rsp_valid_in  = 1'b1;
                     end else if (cur_ff == len_ff) begin
                        // erasing the tail needs no shift
                        len_in       = len_ff - ONE_L;
                        cur_in       = cur_ff - ONE_L;
                        rsp_valid_in = 1'b1;
                     end else begin
                        ptr_in = cur_ff;
                     end
                  end
                  FUNC_PRINT: begin
                     pack_ctl.clear = 1'b1;
                     idx_in         = '0;
                     sep_done_in    = 1'b0;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         ST_SHIFT: begin
            // read one entry, write back the one read last cycle
            mem_re    = 1'b1;
            mem_raddr = ptr_ff[AW-1:0];
            mem_we    = pend_ff;
            mem_waddr = wptr_ff[AW-1:0];
            pend_in   = 1'b1;
            wptr_in   = is_type_ff ? (ptr_ff + ONE_L) : (ptr_ff - ONE_L);
            if (!shift_last) ptr_in = is_type_ff ? (ptr_ff - ONE_L) : (ptr_ff + ONE_L);
         end

         ST_DRAIN: begin
            mem_we    = 1'b1;
            mem_waddr = wptr_ff[AW-1:0];
            if (!is_type_ff) begin
               len_in        = len_ff - ONE_L;
               cur_in        = cur_ff - ONE_L;
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_DONE;
               rsp_chunk_in  = '0;
               rsp_count_in  = '0;
               rsp_last_in   = 1'b1;
            end
         end

         ST_INSERT: begin
            mem_we        = 1'b1;
            mem_waddr     = cur_ff[AW-1:0];
            mem_wdata     = key_ff;
            len_in        = len_ff + ONE_L;
            cur_in        = cur_ff + ONE_L;
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_DONE;
            rsp_chunk_in  = '0;
            rsp_count_in  = '0;
            rsp_last_in   = 1'b1;
         end

         ST_PRINT_FETCH: begin
            mem_re    = 1'b1;
            mem_raddr = '0;
         end

         ST_PRINT: begin
            rsp_status_in = STATUS_DONE;
            if (sep_now || idx_ff != len_ff) begin
               pack_ctl.push = 1'b1;
               if (sep_now) begin
                  pack_byte   = sep_ff;
                  sep_done_in = 1'b1;
               end else begin
                  idx_in = idx_nx;
                  if (idx_nx < len_ff) begin
                     mem_re    = 1'b1;
                     mem_raddr = idx_nx[AW-1:0];
                  end
               end
               // a full chunk goes out once another byte is known to follow
               if (pack_count == COUNT_FULL) begin
                  rsp_valid_in = 1'b1;
                  rsp_chunk_in = pack_chunk;
                  rsp_count_in = COUNT_FULL;
                  rsp_last_in  = 1'b0;
               end
            end else begin
               rsp_valid_in = 1'b1;
               rsp_chunk_in = pack_chunk;
               rsp_count_in = pack_count;
               rsp_last_in  = 1'b1;
            end
         end

         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   lebc_packer u_packer (
      .clock     (clock),
      .reset     (reset),
      .ctl       (pack_ctl),
      .push_byte (pack_byte),
      .chunk     (pack_chunk),
      .count     (pack_count)
   );

   // store
   always_ff @(posedge clock) begin
      if (mem_we) store_mem[mem_waddr] <= mem_wdata;
      if (mem_re) rd_data_ff <= store_mem[mem_raddr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         cur_ff       <= '0;
         maxlen_ff    <= MAX_LENGTH_RESET;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         sep_done_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         cur_ff       <= cur_in;
         maxlen_ff    <= maxlen_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         sep_done_ff  <= sep_done_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      wptr_ff       <= wptr_in;
      is_type_ff    <= is_type_in;
      key_ff        <= key_in;
      sep_ff        <= sep_in;
      idx_ff        <= idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_chunk_ff  <= rsp_chunk_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_text_chunk = rsp_chunk_ff;
   assign rsp_byte_count = rsp_count_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// File: rtl/lebc_checker.sv
// Port-level checker for the line edit buffer, bound to the top level.
// Depends on lebc_pkg and line_edit_buffer_with_cursor_top_macros.svh.
`include "line_edit_buffer_with_cursor_top_macros.svh"

module lebc_checker
   import lebc_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                rsp_valid,
   input logic                rsp_status,
   input logic [COUNT_W-1:0]  rsp_byte_count,
   input logic                rsp_last
);

   // a request is answered at once or the block goes busy
   `LEBC_ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, rsp_valid || busy, "request neither answered nor busy")

   // more chunks pending means the print is still running
   `LEBC_ASSERT_NOW(a_more_busy, clock, reset, rsp_valid && !rsp_last, busy, "non-final chunk while idle")

   // only full chunks are non-final
   `LEBC_ASSERT_NOW(a_mid_full, clock, reset, rsp_valid && !rsp_last, rsp_byte_count == COUNT_FULL, "short non-final chunk")

   // a refusal is a single empty result
   `LEBC_ASSERT_NOW(a_refused_single, clock, reset, rsp_valid && rsp_status, rsp_last && (rsp_byte_count == '0), "refusal carries data")

endmodule

bind line_edit_buffer_with_cursor_top lebc_checker u_lebc_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_status     (rsp_status),
   .rsp_byte_count (rsp_byte_count),
   .rsp_last       (rsp_last)
);

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for the one-line edit buffer with cursor.
// Needs lebc_pkg and line_edit_buffer_with_cursor_top; keeps its own shadow of the
// line, cursor and max_length and checks every result chunk against it.
module tb_top;
   import lebc_pkg::*;

   localparam int BUFFER_DEPTH = 128;
   localparam int CYCLE_LIMIT  = 600000;    // slowest legal run stays well under this limit
   localparam int DIRECTED_ROWS = 24;

   // code 7 has no meaning; the block must answer it with a plain done
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 3'd7;

   // one expected result on the rsp_ ports
   typedef struct packed {
      logic               status;
      logic [CHUNK_W-1:0] chunk;
      logic [COUNT_W-1:0] count;
      logic               last;
   } chunk_rsp_type;

   // one row of the directed table; has_lit marks rows whose single result is typed in
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [7:0]        key;
      logic [7:0]        sep;
      logic              has_lit;
      logic              lit_st;
   } keystroke_row_type;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [FUNC_W-1:0]    req_func;
   logic [7:0]           req_key_byte;
   logic [7:0]           req_separator_byte;
   logic                 rsp_valid;
   logic                 rsp_status;
   logic [CHUNK_W-1:0]   rsp_text_chunk;
   logic [COUNT_W-1:0]   rsp_byte_count;
   logic                 rsp_last;
   logic                 csr_wr_en;
   logic [7:0]           csr_wr_data;

   line_edit_buffer_with_cursor_top #(
      .BUFFER_DEPTH(BUFFER_DEPTH)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_func           (req_func),
      .req_key_byte       (req_key_byte),
      .req_separator_byte (req_separator_byte),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_text_chunk     (rsp_text_chunk),
      .rsp_byte_count     (rsp_byte_count),
      .rsp_last           (rsp_last),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   // Shadow of the block's state, touched only at rising edges (and read by the
   // driver at falling edges, so never in the same step it changes).
   logic [STORE_W-1:0] shadow_text [BUFFER_DEPTH];
   int                 shadow_len;
   int                 shadow_cursor;
   logic [7:0]         shadow_max_len;

   chunk_rsp_type pending_chunks [$];   // chunks the block still owes, oldest first
   chunk_rsp_type fresh_chunks [$];     // chunks of the request just taken

   int   mismatch_count = 0;
   int   cycle_count = 0;
   int   idle_pct;                   // chance in a hundred that the sender idles a cycle
   logic req_taken = 1'b0;           // a request went in at the last rising edge
   logic lit_on = 1'b0;              // current request carries a typed-in result
   logic lit_status = STATUS_DONE;

   keystroke_row_type directed_rows [DIRECTED_ROWS] = '{
      {FUNC_PRINT,  8'h00, 8'h00, 1'b1, STATUS_DONE},    // print of nothing
      {FUNC_ERASE,  8'h00, 8'h00, 1'b1, STATUS_REFUSED}, // erase at the start
      {FUNC_END,    8'h00, 8'h00, 1'b1, STATUS_DONE},    // end on empty line
      {FUNC_LEFT,   8'h00, 8'h00, 1'b1, STATUS_DONE},    // left at the start
      {FUNC_RIGHT,  8'h00, 8'h00, 1'b1, STATUS_DONE},    // right at the end
      {FUNC_TYPE,   8'h1F, 8'h00, 1'b1, STATUS_REFUSED}, // just below printable
      {FUNC_TYPE,   8'h7F, 8'h00, 1'b1, STATUS_REFUSED}, // just above printable
      {FUNC_TYPE,   8'hFF, 8'h00, 1'b1, STATUS_REFUSED},
      {FUNC_TYPE,   8'h00, 8'h00, 1'b1, STATUS_REFUSED},
      {FUNC_TYPE,   8'h20, 8'h00, 1'b1, STATUS_DONE},    // lowest printable
      {FUNC_TYPE,   8'h7E, 8'h00, 1'b1, STATUS_DONE},    // highest printable
      {FUNC_PRINT,  8'h00, 8'h00, 1'b0, STATUS_DONE},
      {FUNC_PRINT,  8'h00, 8'hFF, 1'b0, STATUS_DONE},    // marker at the end
      {FUNC_HOME,   8'h00, 8'h00, 1'b1, STATUS_DONE},
      {FUNC_PRINT,  8'h00, 8'h5F, 1'b0, STATUS_DONE},    // marker goes first
      {FUNC_TYPE,   8'h41, 8'h00, 1'b1, STATUS_DONE},    // insert in front, shifts line
      {FUNC_RIGHT,  8'h00, 8'h00, 1'b0, STATUS_DONE},
      {FUNC_ERASE,  8'h00, 8'h00, 1'b0, STATUS_DONE},    // erase mid-line
      {FUNC_UNUSED, 8'hAA, 8'h55, 1'b1, STATUS_DONE},    // meaningless code
      {FUNC_END,    8'h00, 8'h00, 1'b0, STATUS_DONE},
      {FUNC_ERASE,  8'h00, 8'h00, 1'b0, STATUS_DONE},    // erase at the end
      {FUNC_LEFT,   8'h00, 8'h00, 1'b0, STATUS_DONE},
      {FUNC_PRINT,  8'h00, 8'h01, 1'b0, STATUS_DONE},
      {FUNC_PRINT,  8'h00, 8'h00, 1'b0, STATUS_DONE}
   };

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Works out the chunks one keystroke gives and moves the shadow state on.
   task automatic predict_keystroke(input logic [FUNC_W-1:0] f, input logic [7:0] k,
                                    input logic [7:0] s);
      logic [7:0]    line [0:BUFFER_DEPTH];
      int            n;
      int            i;
      int            j;
      int            cnt;
      chunk_rsp_type r;
      logic          st;
      fresh_chunks.delete();
      st = STATUS_DONE;
      if (f == FUNC_PRINT) begin
         // lay out text with the marker in the cursor gap, then cut into chunks
         n = 0;
         for (i = 0; i <= shadow_len; i++) begin
            if (i == shadow_cursor && s != 8'h00) begin
               line[n] = s;
               n++;
            end
            if (i < shadow_len) begin
               line[n] = {1'b0, shadow_text[i]};
               n++;
            end
         end
         if (n == 0) begin
            fresh_chunks.insert(fresh_chunks.size(),
                                {STATUS_DONE, {CHUNK_W{1'b0}}, {COUNT_W{1'b0}}, 1'b1});
         end
         for (i = 0; i < n; i += CHUNK_BYTES) begin
            cnt = (n - i > CHUNK_BYTES) ? CHUNK_BYTES : n - i;
            r = '0;
            for (j = 0; j < cnt; j++) r.chunk[8*j +: 8] = line[i + j];
            r.status = STATUS_DONE;
            r.count = COUNT_W'(cnt);
            r.last = (i + cnt >= n);
            fresh_chunks.insert(fresh_chunks.size(), r);
         end
      end else begin
         case (f)
            FUNC_HOME:  shadow_cursor = 0;
            FUNC_END:   shadow_cursor = shadow_len;
            FUNC_LEFT:  if (shadow_cursor > 0) shadow_cursor--;
            FUNC_RIGHT: if (shadow_cursor < shadow_len) shadow_cursor++;
            FUNC_TYPE: begin
               if (k < PRINT_LOW || k > PRINT_HIGH || shadow_len >= shadow_max_len ||
                   shadow_len >= BUFFER_DEPTH) begin
                  st = STATUS_REFUSED;
               end else begin
                  for (i = shadow_len; i > shadow_cursor; i--) shadow_text[i] = shadow_text[i-1];
                  shadow_text[shadow_cursor] = k[STORE_W-1:0];
                  shadow_len++;
                  shadow_cursor++;
               end
            end
            FUNC_ERASE: begin
               if (shadow_cursor == 0) begin
                  st = STATUS_REFUSED;
               end else begin
                  for (i = shadow_cursor - 1; i + 1 < shadow_len; i++)
                     shadow_text[i] = shadow_text[i+1];
                  shadow_len--;
                  shadow_cursor--;
               end
            end
            default: ;
         endcase
         fresh_chunks.insert(fresh_chunks.size(),
                             {st, {CHUNK_W{1'b0}}, {COUNT_W{1'b0}}, 1'b1});
      end
   endtask

   task automatic check_field(input string name, input logic [CHUNK_W-1:0] want,
                              input logic [CHUNK_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Rising edge: results are checked, csr writes and requests are taken into
   // the shadow. Results of a request show no earlier than the next edge, so the
   // order of the three below does not matter.
   always @(posedge clock) begin : watch_ports
      chunk_rsp_type want;
      req_taken <= start && !busy && !reset;
      if (reset) begin
         shadow_len = 0;
         shadow_cursor = 0;
         shadow_max_len = MAX_LENGTH_RESET;
         pending_chunks.delete();
      end else begin
         if (rsp_valid) begin
            if (pending_chunks.size() == 0) begin
               $display("%0t: result with nothing pending: expected none, got chunk %h count %0d",
                        $time, rsp_text_chunk, rsp_byte_count);
               mismatch_count++;
            end else begin
               want = pending_chunks.pop_front();
               check_field("status", CHUNK_W'(want.status), CHUNK_W'(rsp_status));
               check_field("text_chunk", want.chunk, rsp_text_chunk);
               check_field("byte_count", CHUNK_W'(want.count), CHUNK_W'(rsp_byte_count));
               check_field("last", CHUNK_W'(want.last), CHUNK_W'(rsp_last));
            end
         end
         if (csr_wr_en) shadow_max_len = csr_wr_data;
         if (start && !busy) begin
            predict_keystroke(req_func, req_key_byte, req_separator_byte);
            if (lit_on)
               pending_chunks.insert(pending_chunks.size(),
                                     {lit_status, {CHUNK_W{1'b0}}, {COUNT_W{1'b0}}, 1'b1});
            else
               foreach (fresh_chunks[i])
                  pending_chunks.insert(pending_chunks.size(), fresh_chunks[i]);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Called at a falling edge; returns at the falling edge after the request is taken.
   task automatic send_keystroke(input logic [FUNC_W-1:0] f, input logic [7:0] k,
                                 input logic [7:0] s, input logic lit, input logic lit_st);
      while ($urandom_range(0, 99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      req_func = f;
      req_key_byte = k;
      req_separator_byte = s;
      lit_on = lit;
      lit_status = lit_st;
      start = 1'b1;
      do @(negedge clock); while (!req_taken);
   endtask

   // Hold off until the block owes nothing and is idle again.
   task automatic wait_for_drain();
      start = 1'b0;
      while (pending_chunks.size() != 0 || busy) @(negedge clock);
   endtask

   task automatic write_max_length(input logic [7:0] v);
      wait_for_drain();
      csr_wr_data = v;
      csr_wr_en = 1'b1;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // Mostly real editing: printable typing, moves, erases and prints; a share of
   // non-printable keys and the unused code as noise.
   task automatic random_keystroke(input int type_wt, input int erase_wt);
      int                r;
      logic [FUNC_W-1:0] f;
      logic [7:0]        k;
      logic [7:0]        s;
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 85) k = 8'($urandom_range(PRINT_LOW, PRINT_HIGH));
      else k = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 3) == 0) s = 8'h00;
      else s = 8'($urandom_range(0, 255));
      if (r < type_wt) f = FUNC_TYPE;
      else if (r < type_wt + erase_wt) f = FUNC_ERASE;
      else if (r < type_wt + erase_wt + 10) f = FUNC_PRINT;
      else if (r < type_wt + erase_wt + 12) f = FUNC_UNUSED;
      else begin
         case ($urandom_range(0, 5))
            0:       f = FUNC_HOME;
            1:       f = FUNC_END;
            2, 3:    f = FUNC_LEFT;
            default: f = FUNC_RIGHT;
         endcase
      end
      // now and then the sender waits for every owed result
      if ($urandom_range(0, 49) == 0) wait_for_drain();
      send_keystroke(f, k, s, 1'b0, STATUS_DONE);
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_func = FUNC_HOME;
      req_key_byte = 8'h00;
      req_separator_byte = 8'h00;
      csr_wr_en = 1'b0;
      csr_wr_data = 8'h00;
      idle_pct = 21;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // directed table, max_length still at its reset value
      foreach (directed_rows[i])
         send_keystroke(directed_rows[i].func, directed_rows[i].key, directed_rows[i].sep,
                        directed_rows[i].has_lit, directed_rows[i].lit_st);

      // phase 1: whole store usable, heavy typing, then fill to the brim and
      // print the full line with and without a marker
      write_max_length(8'd128);
      repeat (140) random_keystroke(70, 5);
      while (shadow_len < BUFFER_DEPTH)
         send_keystroke(FUNC_TYPE, 8'($urandom_range(PRINT_LOW, PRINT_HIGH)), 8'h00, 1'b0,
                        STATUS_DONE);
      send_keystroke(FUNC_TYPE, 8'h61, 8'h00, 1'b1, STATUS_REFUSED);  // store full
      send_keystroke(FUNC_HOME, 8'h00, 8'h00, 1'b1, STATUS_DONE);
      send_keystroke(FUNC_PRINT, 8'h00, 8'h7C, 1'b0, STATUS_DONE);    // 17 chunks
      send_keystroke(FUNC_END, 8'h00, 8'h00, 1'b1, STATUS_DONE);
      send_keystroke(FUNC_PRINT, 8'h00, 8'h00, 1'b0, STATUS_DONE);    // 16 chunks

      // phase 2: sender idles most of the time; no typing allowed at all, then a
      // limit well below the current length while erases whittle the line down
      idle_pct = 68;
      write_max_length(8'd0);
      repeat (25) random_keystroke(40, 30);
      write_max_length(8'd7);
      repeat (120) random_keystroke(35, 30);

      // phase 3: back-to-back requests under a random limit
      idle_pct = 0;
      write_max_length(8'($urandom_range(8, 128)));
      repeat (100) random_keystroke(45, 15);

      wait_for_drain();
      repeat (BUFFER_DEPTH + 8) @(negedge clock);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl
rtl/lebc_pkg.sv
rtl/lebc_packer.sv
rtl/line_edit_buffer_with_cursor_top.sv
rtl/lebc_checker.sv
bench/tb_top.sv
